### sv/gn2_pkg.sv
// Shared types and constants for the 2D gradient noise sampler.
// No dependencies.
package gn2_pkg;
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] REG_HSCALE = 2'd0;
  localparam logic [1:0] REG_VSCALE = 2'd1;

  localparam int SCALE_W = 24;
  localparam int COORD_W = 16;
  localparam int FRAC_W  = 16;
  localparam int GRAD_W  = 16;
  localparam int DOT_W   = 40;
  localparam int WGT_W   = 17;

  localparam logic signed [15:0] NOISE_MAX = 16'sd16384;
  localparam logic signed [15:0] NOISE_MIN = -16'sd16384;

  typedef logic signed [DOT_W-1:0] dot_t;
  typedef logic [WGT_W-1:0] wgt_t;
endpackage

### sv/gn2_wrap.sv
// Cell index wrap: value modulo GRID_SIZE by reciprocal multiply and one correction.
// One register stage inside, result combinational from it. Uses gn2_pkg.
module gn2_wrap #(
  parameter int GRID_SIZE = 256
) (
  input  logic                                 clk,
  input  logic [gn2_pkg::SCALE_W-1:0]          val,
  output logic [$clog2(GRID_SIZE)-1:0]         idx
);
  localparam int CW = $clog2(GRID_SIZE);
  localparam int VW = gn2_pkg::SCALE_W;
  localparam logic [VW-1:0] RECIP = VW'((64'd1 << VW) / GRID_SIZE);
  localparam logic [VW-1:0] GRID  = VW'(GRID_SIZE);

  logic [VW-1:0]   quo_r;
  logic [VW-1:0]   val_r;
  logic [2*VW-1:0] prod;
  logic [2*VW-1:0] back;
  logic [VW-1:0]   rem;
  logic [VW-1:0]   rem_fix;

  assign prod = (2*VW)'(val) * (2*VW)'(RECIP);

  always_ff @(posedge clk) begin
    quo_r <= prod[2*VW-1:VW];
    val_r <= val;
  end

  always_comb begin
    back    = (2*VW)'(quo_r) * (2*VW)'(GRID);
    rem     = val_r - back[VW-1:0];
    rem_fix = (rem >= GRID) ? rem - GRID : rem;
    idx     = rem_fix[CW-1:0];
  end
endmodule

### sv/gradient_noise_2d.sv
// 2D gradient noise sampler, top level. Uses gn2_pkg and gn2_wrap.
// Holds the gradient table in four replicated synchronous memories.
//
// Usage:
//   Input words are taken on start while busy is low; busy stays low, so a
//   word may be issued every cycle. in_opcode selects a gradient load
//   (in_load_row, in_load_col, in_grad_x, in_grad_y) or a noise sample at
//   (in_coord_s, in_coord_t). A load gives no result word.
//   Each sample gives one word: out_valid rises with out_noise_value, both
//   registered after pipeline stages 0 to 4 and the output register.
//   Results leave in issue order; the receiver cannot stall, so none is held.
//   Throughput is one word per cycle, set by the four table copies, one per
//   cell corner, each with one read and one write port.
//   Scale registers are written on cfg_we at cfg_index; other indexes drop.
//   Reset sets both scales to 4096 and clears the pipeline valids. Table
//   contents are undefined until loaded; loads and reads share one stage,
//   so a sample sees every earlier load.
module gradient_noise_2d #(
  parameter int GRID_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [15:0] in_coord_s,
  input  logic [15:0] in_coord_t,
  input  logic [7:0]  in_load_row,
  input  logic [7:0]  in_load_col,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output logic        out_valid,
  output logic signed [15:0] out_noise_value
);
  localparam int CW    = $clog2(GRID_SIZE);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int SW    = gn2_pkg::SCALE_W;
  localparam int PW    = SW + gn2_pkg::COORD_W;
  localparam int FW    = gn2_pkg::FRAC_W;
  localparam int DW    = gn2_pkg::DOT_W;
  localparam logic [CW-1:0] LAST = CW'(GRID_SIZE - 1);

  logic [SW-1:0] hscale_r, vscale_r;

  // stage 0
  logic v0_r, op0_r;
  logic [PW-1:0] ps0_r, pt0_r;
  logic [7:0] row0_r, col0_r;
  logic [31:0] grad0_r;
  // stage 1
  logic v1_r, op1_r;
  logic [FW-1:0] fx1_r, fy1_r;
  logic [2*FW-1:0] fx2_1_r, fy2_1_r;
  logic [31:0] grad1_r;
  // stage 2
  logic [CW-1:0] cx, cy, cx1, cy1;
  logic [AW-1:0] a_ll, a_lr, a_ul, a_ur;
  logic s2_r;
  logic [FW-1:0] fx2_r, fy2_r;
  gn2_pkg::wgt_t wx2_r, wy2_r, wx_nxt, wy_nxt;
  logic [31:0] rd_ll_r, rd_lr_r, rd_ul_r, rd_ur_r;
  logic [31:0] mem_ll [DEPTH];
  logic [31:0] mem_lr [DEPTH];
  logic [31:0] mem_ul [DEPTH];
  logic [31:0] mem_ur [DEPTH];
  // stage 3
  logic s3_r;
  gn2_pkg::dot_t d_ll_r, d_lr_r, d_ul_r, d_ur_r;
  gn2_pkg::wgt_t wx3_r, wy3_r;
  // stage 4
  logic s4_r;
  gn2_pkg::dot_t lower_r, upper_r;
  gn2_pkg::wgt_t wy4_r;
  gn2_pkg::dot_t avg;
  logic signed [DW-1:0] q;
  logic signed [15:0] noise_nxt;

  logic [SW-1:0] xin, yin;

  function automatic gn2_pkg::wgt_t fade(input logic [2*FW-1:0] f2, input logic [FW-1:0] f);
    logic [50:0] f3;
    logic [50:0] w51;
    logic [50:0] wr;
    f3  = 51'(f2) * 51'(f);
    w51 = ((51'(f2) * 51'd3) << 16) - (f3 << 1);
    wr  = (w51 + 51'h80000000) >> 32;
    return wr[gn2_pkg::WGT_W-1:0];
  endfunction

  function automatic gn2_pkg::dot_t dot(input logic [31:0] g, input logic [FW:0] dx,
                                        input logic [FW:0] dy);
    logic signed [32:0] px;
    logic signed [32:0] py;
    px = $signed(g[15:0]) * $signed(dx);
    py = $signed(g[31:16]) * $signed(dy);
    return gn2_pkg::dot_t'(px) + gn2_pkg::dot_t'(py);
  endfunction

  function automatic gn2_pkg::dot_t blend(input gn2_pkg::dot_t a, input gn2_pkg::dot_t b,
                                          input gn2_pkg::wgt_t w);
    logic signed [DW:0]      diff;
    logic signed [DW+18:0]   prod;
    diff = (DW+1)'(b) - (DW+1)'(a);
    prod = $signed({1'b0, w}) * diff;
    prod = (prod + (DW+19)'(32768)) >>> 16;
    return a + prod[DW-1:0];
  endfunction

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hscale_r <= SW'(4096);
      vscale_r <= SW'(4096);
    end else if (cfg_we) begin
      if (cfg_index == gn2_pkg::REG_HSCALE) hscale_r <= cfg_wdata;
      if (cfg_index == gn2_pkg::REG_VSCALE) vscale_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      s2_r <= 1'b0;
      s3_r <= 1'b0;
      s4_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v0_r <= start;
      v1_r <= v0_r;
      s2_r <= v1_r && (op1_r == gn2_pkg::OP_SAMPLE);
      s3_r <= s2_r;
      s4_r <= s3_r;
      out_valid <= s4_r;
    end
  end

  always_ff @(posedge clk) begin
    op0_r   <= in_opcode;
    ps0_r   <= PW'(in_coord_s) * PW'(hscale_r);
    pt0_r   <= PW'(in_coord_t) * PW'(vscale_r);
    row0_r  <= in_load_row;
    col0_r  <= in_load_col;
    grad0_r <= {in_grad_y, in_grad_x};
  end

  assign xin = (op0_r == gn2_pkg::OP_SAMPLE) ? ps0_r[PW-1:FW] : SW'(row0_r);
  assign yin = (op0_r == gn2_pkg::OP_SAMPLE) ? pt0_r[PW-1:FW] : SW'(col0_r);

  gn2_wrap #(.GRID_SIZE(GRID_SIZE)) u_wrap_x (.clk(clk), .val(xin), .idx(cx));
  gn2_wrap #(.GRID_SIZE(GRID_SIZE)) u_wrap_y (.clk(clk), .val(yin), .idx(cy));

  always_ff @(posedge clk) begin
    op1_r   <= op0_r;
    fx1_r   <= ps0_r[FW-1:0];
    fy1_r   <= pt0_r[FW-1:0];
    fx2_1_r <= (2*FW)'(ps0_r[FW-1:0]) * (2*FW)'(ps0_r[FW-1:0]);
    fy2_1_r <= (2*FW)'(pt0_r[FW-1:0]) * (2*FW)'(pt0_r[FW-1:0]);
    grad1_r <= grad0_r;
  end

  always_comb begin
    cx1  = (cx == LAST) ? '0 : cx + CW'(1);
    cy1  = (cy == LAST) ? '0 : cy + CW'(1);
    a_ll = {cx, cy};
    a_lr = {cx1, cy};
    a_ul = {cx, cy1};
    a_ur = {cx1, cy1};
    wx_nxt = fade(fx2_1_r, fx1_r);
    wy_nxt = fade(fy2_1_r, fy1_r);
  end

  always_ff @(posedge clk) begin
    if (v1_r && (op1_r == gn2_pkg::OP_LOAD)) begin
      mem_ll[a_ll] <= grad1_r;
      mem_lr[a_ll] <= grad1_r;
      mem_ul[a_ll] <= grad1_r;
      mem_ur[a_ll] <= grad1_r;
    end
    rd_ll_r <= mem_ll[a_ll];
    rd_lr_r <= mem_lr[a_lr];
    rd_ul_r <= mem_ul[a_ul];
    rd_ur_r <= mem_ur[a_ur];
  end

  always_ff @(posedge clk) begin
    fx2_r <= fx1_r;
    fy2_r <= fy1_r;
    wx2_r <= wx_nxt;
    wy2_r <= wy_nxt;
  end

  always_ff @(posedge clk) begin
    d_ll_r <= dot(rd_ll_r, {1'b0, fx2_r}, {1'b0, fy2_r});
    d_lr_r <= dot(rd_lr_r, {1'b1, fx2_r}, {1'b0, fy2_r});
    d_ul_r <= dot(rd_ul_r, {1'b0, fx2_r}, {1'b1, fy2_r});
    d_ur_r <= dot(rd_ur_r, {1'b1, fx2_r}, {1'b1, fy2_r});
    wx3_r  <= wx2_r;
    wy3_r  <= wy2_r;
  end

  always_ff @(posedge clk) begin
    lower_r <= blend(d_ll_r, d_lr_r, wx3_r);
    upper_r <= blend(d_ul_r, d_ur_r, wx3_r);
    wy4_r   <= wy3_r;
  end

  always_comb begin
    avg = blend(lower_r, upper_r, wy4_r);
    q   = (avg + DW'(32768)) >>> 16;
    priority if (q > DW'(gn2_pkg::NOISE_MAX)) noise_nxt = gn2_pkg::NOISE_MAX;
    else if (q < DW'(gn2_pkg::NOISE_MIN))     noise_nxt = gn2_pkg::NOISE_MIN;
    else                                       noise_nxt = q[15:0];
  end

  always_ff @(posedge clk) begin
    out_noise_value <= noise_nxt;
  end
endmodule

### bench/gn2_noise_checker.sv
`timescale 1ns / 100ps
// Watches the input, config and result ports of gradient_noise_2d, predicts each
// noise sample from its own gradient table and scales, and compares results in order.
// Depends on gn2_pkg.
module gn2_noise_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic              in_opcode,
  input  logic [15:0]       in_coord_s,
  input  logic [15:0]       in_coord_t,
  input  logic [7:0]        in_load_row,
  input  logic [7:0]        in_load_col,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [23:0]       cfg_wdata,
  input  logic              out_valid,
  input  logic signed [15:0] out_noise_value,
  output int                fail_count,
  output int                noise_pending,
  output int                samples_seen
);

  logic [31:0] grad_table [0:65535];
  logic [gn2_pkg::SCALE_W-1:0] hscale, vscale;
  logic signed [15:0] noise_due [$];

  assign noise_pending = noise_due.size();

  initial begin
    for (int i = 0; i < 65536; i++) grad_table[i] = '0;
    fail_count = 0;
    samples_seen = 0;
  end

  function automatic longint corner_dot(logic [31:0] entry, longint dx, longint dy);
    longint gx, gy;
    gx = longint'($signed(entry[15:0]));
    gy = longint'($signed(entry[31:16]));
    return gx * dx + gy * dy;
  endfunction

  function automatic longint fade_weight(longint f);
    longint unsigned f2, f3, w48;
    f2 = f * f;
    f3 = f2 * f;
    w48 = ((3 * f2) << 16) - 2 * f3;
    return longint'((w48 + 64'h8000_0000) >> 32);
  endfunction

  function automatic longint blend(longint a, longint b, longint w);
    return a + ((w * (b - a) + 32768) >>> 16);
  endfunction

  function automatic logic signed [15:0] predict_noise(logic [15:0] s, logic [15:0] t);
    logic [39:0] ps, pt;
    logic [7:0] cx, cy, cx1, cy1;
    longint fx, fy, wx, wy, dll, dlr, dul, dur, lower, upper, avg, q;
    ps = 40'(s) * 40'(hscale);
    pt = 40'(t) * 40'(vscale);
    cx = ps[23:16];
    cy = pt[23:16];
    cx1 = cx + 8'd1;
    cy1 = cy + 8'd1;
    fx = longint'(ps[15:0]);
    fy = longint'(pt[15:0]);
    dll = corner_dot(grad_table[{cx, cy}], fx, fy);
    dlr = corner_dot(grad_table[{cx1, cy}], fx - 65536, fy);
    dul = corner_dot(grad_table[{cx, cy1}], fx, fy - 65536);
    dur = corner_dot(grad_table[{cx1, cy1}], fx - 65536, fy - 65536);
    wx = fade_weight(fx);
    wy = fade_weight(fy);
    lower = blend(dll, dlr, wx);
    upper = blend(dul, dur, wx);
    avg = blend(lower, upper, wy);
    q = (avg + 32768) >>> 16;
    if (q > longint'(gn2_pkg::NOISE_MAX)) q = longint'(gn2_pkg::NOISE_MAX);
    if (q < longint'(gn2_pkg::NOISE_MIN)) q = longint'(gn2_pkg::NOISE_MIN);
    return q[15:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      hscale <= 24'd4096;
      vscale <= 24'd4096;
      noise_due.delete();
    end else begin
      if (out_valid) begin
        if (noise_due.size() == 0) begin
          $error("noise_value: unexpected word %0d", out_noise_value);
          fail_count++;
        end else begin
          if (out_noise_value !== noise_due[0]) begin
            $error("noise_value: expected %0d, got %0d", noise_due[0], out_noise_value);
            fail_count++;
          end
          void'(noise_due.pop_front());
        end
      end
      if (cfg_we) begin
        if (cfg_index == gn2_pkg::REG_HSCALE) hscale <= cfg_wdata;
        else if (cfg_index == gn2_pkg::REG_VSCALE) vscale <= cfg_wdata;
      end
      if (start && !busy) begin
        if (in_opcode == gn2_pkg::OP_LOAD)
          grad_table[{in_load_row, in_load_col}] = {in_grad_y, in_grad_x};
        else begin
          noise_due.push_back(predict_noise(in_coord_s, in_coord_t));
          samples_seen++;
        end
      end
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// Stimulus and verdict for gradient_noise_2d: directed and random loads and
// samples over several scale settings. Depends on gn2_pkg, gradient_noise_2d and gn2_noise_checker.
module tb_top;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;

  logic clk, rst_n, start, busy, in_opcode, cfg_we, out_valid;
  logic [15:0] in_coord_s, in_coord_t;
  logic [7:0] in_load_row, in_load_col;
  logic signed [15:0] in_grad_x, in_grad_y, out_noise_value;
  logic [1:0] cfg_index;
  logic [23:0] cfg_wdata;
  int fail_count, noise_pending, samples_seen, idle_cycles, loads_sent, items_sent;
  logic [23:0] cur_hscale, cur_vscale;
  bit loaded [0:65535];
  bit no_gaps;

  gradient_noise_2d dut (.*);

  gn2_noise_checker checker_i (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] rand_grad();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom);
    if (r == 1) return ($urandom_range(0, 1) != 0) ? gn2_pkg::NOISE_MAX : gn2_pkg::NOISE_MIN;
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    n = no_gaps ? 0 : (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(5, 30);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_word(logic op, logic [15:0] s, logic [15:0] t, logic [7:0] row,
                           logic [7:0] col, logic [15:0] gx, logic [15:0] gy);
    start <= 1'b1;
    in_opcode <= op;
    in_coord_s <= s;
    in_coord_t <= t;
    in_load_row <= row;
    in_load_col <= col;
    in_grad_x <= gx;
    in_grad_y <= gy;
    items_sent++;
    do @(posedge clk); while (busy);
    @(negedge clk);
    idle_gap();
  endtask

  task automatic load_grad(logic [7:0] row, logic [7:0] col, logic [15:0] gx, logic [15:0] gy);
    loaded[{row, col}] = 1'b1;
    loads_sent++;
    send_word(gn2_pkg::OP_LOAD, 16'($urandom), 16'($urandom), row, col, gx, gy);
  endtask

  task automatic sample_at(logic [15:0] s, logic [15:0] t);
    logic [39:0] ps, pt;
    logic [7:0] cx, cy;
    ps = 40'(s) * 40'(cur_hscale);
    pt = 40'(t) * 40'(cur_vscale);
    cx = ps[23:16];
    cy = pt[23:16];
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        if (!loaded[{8'(cx + i), 8'(cy + j)}])
          load_grad(8'(cx + i), 8'(cy + j), rand_grad(), rand_grad());
    send_word(gn2_pkg::OP_SAMPLE, s, t, 8'($urandom), 8'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  task automatic write_scale(logic [1:0] idx, logic [23:0] val);
    start <= 1'b0;
    @(negedge clk);
    while (noise_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == gn2_pkg::REG_HSCALE) cur_hscale = val;
    else if (idx == gn2_pkg::REG_VSCALE) cur_vscale = val;
  endtask

  task automatic random_phase(int n);
    logic [15:0] s, t;
    int stop, k;
    stop = items_sent + n;
    k = 0;
    while (items_sent < stop) begin
      if (k % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      k++;
      if ($urandom_range(0, 9) < 4)
        load_grad(8'($urandom), 8'($urandom), rand_grad(), rand_grad());
      else begin
        s = ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'($urandom);
        t = ($urandom_range(0, 15) == 0) ? 16'h0000 : 16'($urandom);
        sample_at(s, t);
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    start = 1'b0; in_opcode = gn2_pkg::OP_LOAD; in_coord_s = '0; in_coord_t = '0;
    in_load_row = '0; in_load_col = '0; in_grad_x = '0; in_grad_y = '0;
    cfg_we = 1'b0; cfg_index = gn2_pkg::REG_HSCALE; cfg_wdata = '0;
    rst_n = 1'b0; no_gaps = 1'b0; loads_sent = 0; idle_cycles = 0; items_sent = 0;
    cur_hscale = 24'd4096; cur_vscale = 24'd4096;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extreme gradients, table edges, wrap at the last cell
    load_grad(8'd0, 8'd0, gn2_pkg::NOISE_MAX, gn2_pkg::NOISE_MAX);
    load_grad(8'd1, 8'd0, gn2_pkg::NOISE_MIN, gn2_pkg::NOISE_MAX);
    load_grad(8'd0, 8'd1, gn2_pkg::NOISE_MAX, gn2_pkg::NOISE_MIN);
    load_grad(8'd1, 8'd1, gn2_pkg::NOISE_MIN, gn2_pkg::NOISE_MIN);
    sample_at(16'd0, 16'd0);
    sample_at(16'd8, 16'd8);
    sample_at(16'd15, 16'd1);
    load_grad(8'd255, 8'd255, 16'h7FFF, 16'h8000);
    load_grad(8'd0, 8'd255, 16'h8000, 16'h7FFF);
    load_grad(8'd255, 8'd0, 16'hFFFF, 16'h0001);
    write_scale(gn2_pkg::REG_HSCALE, 24'd65536);
    write_scale(gn2_pkg::REG_VSCALE, 24'hFFFFFF);
    sample_at(16'hFFFF, 16'hFFFF);
    sample_at(16'hFFFF, 16'd0);
    sample_at(16'd255, 16'd1);
    write_scale(REG_UNUSED, 24'h123456);
    sample_at(16'd255, 16'd2);
    write_scale(gn2_pkg::REG_HSCALE, 24'd0);
    write_scale(gn2_pkg::REG_VSCALE, 24'd0);
    sample_at(16'hFFFF, 16'hFFFF);

    random_phase(320);
    write_scale(gn2_pkg::REG_HSCALE, 24'hFFFFFF);
    write_scale(gn2_pkg::REG_VSCALE, 24'hFFFFFF);
    random_phase(320);
    write_scale(gn2_pkg::REG_HSCALE, 24'd4096);
    write_scale(gn2_pkg::REG_VSCALE, 24'd4096);
    random_phase(320);
    write_scale(gn2_pkg::REG_HSCALE, 24'($urandom_range(1, 200000)));
    write_scale(gn2_pkg::REG_VSCALE, 24'($urandom));
    random_phase(320);
    write_scale(gn2_pkg::REG_HSCALE, 24'd65536);
    write_scale(gn2_pkg::REG_VSCALE, 24'($urandom_range(1, 4096)));
    write_scale(REG_UNUSED - 2'd1, 24'($urandom));
    random_phase(320);
    write_scale(gn2_pkg::REG_HSCALE, 24'($urandom));
    write_scale(gn2_pkg::REG_VSCALE, 24'd0);
    random_phase(300);

    start <= 1'b0;
    while (noise_pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    $display("Covered %0d noise samples and %0d gradient loads over eight scale settings.",
             samples_seen, loads_sent);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
sv/gn2_pkg.sv
sv/gn2_wrap.sv
sv/gradient_noise_2d.sv
bench/gn2_noise_checker.sv
bench/tb_top.sv
